// File: src/pointer_to_relative_mouse_reports_defines.svh
// Assertion macros shared by the pointer-to-relative-report block.
// The enclosing module must provide clk and rst.
`ifndef POINTER_TO_RELATIVE_MOUSE_REPORTS_DEFINES_SVH
`define POINTER_TO_RELATIVE_MOUSE_REPORTS_DEFINES_SVH

`ifndef ASSERT_OFF
`define PRMR_ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`define PRMR_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define PRMR_ASSERT_IMPL(label, pre, post, msg)
`define PRMR_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

// File: src/prmr_pkg.sv
package prmr_pkg;

  // Coordinate and chunk sizing.
  localparam int COORD_BITS  = 12;
  localparam int CHUNK_LIMIT = 127;
  localparam int COORD_MAX   = (1 << COORD_BITS) - 1;

  // Fixed field widths.
  localparam int SIZE_W    = 13;
  localparam int ABS_W     = 16;
  localparam int REL_W     = 13;
  localparam int REPORT_W  = 8;
  localparam int CFG_IDX_W = 1;

  // Motion deltas must hold an absolute difference and a relative move.
  localparam int DELTA_W = (COORD_BITS + 1 > REL_W) ? COORD_BITS + 1 : REL_W;
  localparam int SUM_W   = DELTA_W + 1;

  localparam logic signed [DELTA_W-1:0] CHUNK_POS = DELTA_W'(CHUNK_LIMIT);
  localparam logic signed [DELTA_W-1:0] CHUNK_NEG = -CHUNK_POS;
  localparam logic signed [REL_W-1:0]   REL_MIN   = {1'b1, {(REL_W-1){1'b0}}};

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(1920);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(1080);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_ABS  = 2'd0,
    OP_REL  = 2'd1,
    OP_LINK = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_MOVE,
    ST_TAIL
  } state_t;

  typedef struct packed {
    logic capture;
    logic prep;
    logic push_chunk;
    logic push_tail;
  } dp_cmd_t;

  typedef struct packed {
    logic       slot_free;
    logic [1:0] op;
    logic       first_abs;
    logic       prep_zero;
    logic       rem_zero;
    logic       rem_next_zero;
    logic       wheel_zero;
    logic       buttons_zero;
  } dp_status_t;

  // Largest coordinate for a screen size; zero acts as one.
  function automatic logic [COORD_BITS-1:0] max_coord(input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] m;
    m = (size == '0) ? '0 : size - SIZE_W'(1);
    if (int'(m) > COORD_MAX) return '1;
    return COORD_BITS'(m);
  endfunction

  // One report's worth of motion on one axis.
  function automatic logic signed [REPORT_W-1:0] chunk(input logic signed [DELTA_W-1:0] d);
    if (d > CHUNK_POS) return REPORT_W'(CHUNK_POS);
    if (d < CHUNK_NEG) return REPORT_W'(CHUNK_NEG);
    return REPORT_W'(d);
  endfunction

endpackage

// File: src/prmr_if.sv
// Pointer event channel.
interface prmr_pointer_if
  import prmr_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [1:0]              opcode;
  logic [7:0]              button_mask;
  logic signed [7:0]       wheel_step;
  logic [ABS_W-1:0]        abs_x;
  logic [ABS_W-1:0]        abs_y;
  logic signed [REL_W-1:0] rel_dx;
  logic signed [REL_W-1:0] rel_dy;

  modport source (output valid, opcode, button_mask, wheel_step, abs_x, abs_y, rel_dx, rel_dy,
                  input ready);
  modport sink (input valid, opcode, button_mask, wheel_step, abs_x, abs_y, rel_dx, rel_dy,
                output ready);
endinterface

// Mouse report channel.
interface prmr_report_if
  import prmr_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic [REPORT_W-1:0]        report_buttons;
  logic signed [REPORT_W-1:0] report_dx;
  logic signed [REPORT_W-1:0] report_dy;
  logic signed [REPORT_W-1:0] report_wheel;
  logic                       last_report;

  modport source (output valid, report_buttons, report_dx, report_dy, report_wheel,
                  last_report, input ready);
  modport sink (input valid, report_buttons, report_dx, report_dy, report_wheel,
                last_report, output ready);
endinterface

// File: src/prmr_dp.sv
module prmr_dp
  import prmr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [SIZE_W-1:0]       cfg_data,
  input  logic [1:0]              opcode,
  input  logic [7:0]              button_mask,
  input  logic signed [7:0]       wheel_step,
  input  logic [ABS_W-1:0]        abs_x,
  input  logic [ABS_W-1:0]        abs_y,
  input  logic signed [REL_W-1:0] rel_dx,
  input  logic signed [REL_W-1:0] rel_dy,
  input  dp_cmd_t                 cmd,
  output dp_status_t              st,
  prmr_report_if.source           report
);

  logic [SIZE_W-1:0]          screen_width;
  logic [SIZE_W-1:0]          screen_height;
  logic [COORD_BITS-1:0]      tracked_x;
  logic [COORD_BITS-1:0]      tracked_y;
  logic                       known;
  logic [1:0]                 op;
  logic [7:0]                 buttons;
  logic signed [7:0]          wheel;
  logic [COORD_BITS-1:0]      in_x;
  logic [COORD_BITS-1:0]      in_y;
  logic signed [DELTA_W-1:0]  in_dx;
  logic signed [DELTA_W-1:0]  in_dy;
  logic signed [DELTA_W-1:0]  rem_dx;
  logic signed [DELTA_W-1:0]  rem_dy;
  logic                       out_valid;

  logic [COORD_BITS-1:0]      mx;
  logic [COORD_BITS-1:0]      my;
  logic signed [REL_W-1:0]    sat_dx;
  logic signed [REL_W-1:0]    sat_dy;
  logic signed [SUM_W-1:0]    abs_dx;
  logic signed [SUM_W-1:0]    abs_dy;
  logic signed [SUM_W-1:0]    sum_x;
  logic signed [SUM_W-1:0]    sum_y;
  logic [COORD_BITS-1:0]      rel_x;
  logic [COORD_BITS-1:0]      rel_y;
  logic signed [DELTA_W-1:0]  delta_x;
  logic signed [DELTA_W-1:0]  delta_y;
  logic signed [REPORT_W-1:0] cx;
  logic signed [REPORT_W-1:0] cy;
  logic signed [DELTA_W-1:0]  rem_dx_next;
  logic signed [DELTA_W-1:0]  rem_dy_next;

  // Screen limits.
  assign mx = max_coord(screen_width);
  assign my = max_coord(screen_height);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= WIDTH_RESET;
      screen_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Relative deltas of the most negative code count as one step less.
  assign sat_dx = (rel_dx == REL_MIN) ? REL_MIN + REL_W'(1) : rel_dx;
  assign sat_dy = (rel_dy == REL_MIN) ? REL_MIN + REL_W'(1) : rel_dy;

  // Request capture: absolute positions are clamped on the way in.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op      <= opcode;
      buttons <= button_mask;
      wheel   <= wheel_step;
      in_x    <= (abs_x > ABS_W'(mx)) ? mx : abs_x[COORD_BITS-1:0];
      in_y    <= (abs_y > ABS_W'(my)) ? my : abs_y[COORD_BITS-1:0];
      in_dx   <= DELTA_W'(sat_dx);
      in_dy   <= DELTA_W'(sat_dy);
    end
  end

  // Absolute difference and clamped relative position.
  assign abs_dx = SUM_W'($signed({1'b0, in_x})) - SUM_W'($signed({1'b0, tracked_x}));
  assign abs_dy = SUM_W'($signed({1'b0, in_y})) - SUM_W'($signed({1'b0, tracked_y}));
  assign sum_x  = SUM_W'($signed({1'b0, tracked_x})) + SUM_W'(in_dx);
  assign sum_y  = SUM_W'($signed({1'b0, tracked_y})) + SUM_W'(in_dy);

  always_comb begin
    if (sum_x < 0) begin
      rel_x = '0;
    end else if (sum_x > SUM_W'($signed({1'b0, mx}))) begin
      rel_x = mx;
    end else begin
      rel_x = sum_x[COORD_BITS-1:0];
    end
    if (sum_y < 0) begin
      rel_y = '0;
    end else if (sum_y > SUM_W'($signed({1'b0, my}))) begin
      rel_y = my;
    end else begin
      rel_y = sum_y[COORD_BITS-1:0];
    end
  end

  assign delta_x = (op == OP_ABS) ? DELTA_W'(abs_dx) : in_dx;
  assign delta_y = (op == OP_ABS) ? DELTA_W'(abs_dy) : in_dy;

  // Current chunk and what remains after it.
  assign cx          = chunk(rem_dx);
  assign cy          = chunk(rem_dy);
  assign rem_dx_next = rem_dx - DELTA_W'(cx);
  assign rem_dy_next = rem_dy - DELTA_W'(cy);

  // Tracked position and remaining motion.
  always_ff @(posedge clk) begin
    if (rst) begin
      tracked_x <= '0;
      tracked_y <= '0;
      known     <= 1'b0;
    end else if (cmd.prep) begin
      case (op)
        OP_ABS: begin
          tracked_x <= in_x;
          tracked_y <= in_y;
          known     <= 1'b1;
        end
        OP_REL: begin
          tracked_x <= rel_x;
          tracked_y <= rel_y;
          known     <= 1'b1;
        end
        OP_LINK: known <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      rem_dx <= delta_x;
      rem_dy <= delta_y;
    end else if (cmd.push_chunk) begin
      rem_dx <= rem_dx_next;
      rem_dy <= rem_dy_next;
    end
  end

  // Output register: holds one report until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push_chunk || cmd.push_tail) begin
      out_valid <= 1'b1;
    end else if (report.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_chunk) begin
      report.report_buttons <= buttons;
      report.report_dx      <= cx;
      report.report_dy      <= cy;
      report.report_wheel   <= '0;
      report.last_report    <= (rem_dx_next == '0) && (rem_dy_next == '0) && (wheel == '0);
    end else if (cmd.push_tail) begin
      report.report_buttons <= buttons;
      report.report_dx      <= '0;
      report.report_dy      <= '0;
      report.report_wheel   <= wheel;
      report.last_report    <= 1'b1;
    end
  end

  assign report.valid = out_valid;

  // Status toward the controller.
  assign st.slot_free     = !out_valid || report.ready;
  assign st.op            = op;
  assign st.first_abs     = (op == OP_ABS) && !known;
  assign st.prep_zero     = (delta_x == '0) && (delta_y == '0);
  assign st.rem_zero      = (rem_dx == '0) && (rem_dy == '0);
  assign st.rem_next_zero = (rem_dx_next == '0) && (rem_dy_next == '0);
  assign st.wheel_zero    = (wheel == '0);
  assign st.buttons_zero  = (buttons == '0);

endmodule

// File: src/prmr_ctrl.sv
`include "pointer_to_relative_mouse_reports_defines.svh"

module prmr_ctrl
  import prmr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        // No request is taken while reset is held.
        in_ready    = !rst;
        cmd.capture = in_valid && !rst;
        if (in_valid && !rst) state_next = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep = 1'b1;
        case (st.op)
          OP_ABS, OP_REL: begin
            if (st.first_abs) begin
              state_next = (st.wheel_zero && st.buttons_zero) ? ST_IDLE : ST_TAIL;
            end else begin
              state_next = st.prep_zero ? ST_TAIL : ST_MOVE;
            end
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_MOVE: begin
        if (st.slot_free) begin
          cmd.push_chunk = 1'b1;
          if (st.rem_next_zero) state_next = st.wheel_zero ? ST_IDLE : ST_TAIL;
        end
      end
      ST_TAIL: begin
        if (st.slot_free) begin
          cmd.push_tail = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Checks on the sequencing.
  `PRMR_ASSERT_IMPL(a_move_has_motion, state == ST_MOVE, !st.rem_zero, "no motion left")
  `PRMR_ASSERT_NEXT(a_capture_then_prep, cmd.capture, state == ST_PREP, "request not prepared")
  `PRMR_ASSERT_NEXT(a_first_abs, cmd.prep && st.first_abs, state != ST_MOVE, "first abs moved")
  `PRMR_ASSERT_NEXT(a_tail_ends, cmd.push_tail, state == ST_IDLE, "tail did not end")

endmodule

// File: src/pointer_to_relative_mouse_reports.sv
// Channel   Direction  Handshake          Payload
// pointer   in         valid / ready      opcode, button_mask, wheel_step, abs_x/y, rel_dx/dy
// report    out        valid / ready      report_buttons, report_dx/dy, report_wheel, last_report
// cfg       in         cfg_we (no ready)  cfg_index, cfg_data
//
// A request is accepted into the capture registers, then prepared, then sent as reports:
// max(ceil(|dx|/127), ceil(|dy|/127)) chunks, none on a first absolute request, then any tail report.
// The chunk sequencer emits one report per cycle, while the sink keeps taking them, into a single output register.
// A stalled report holds the sequencer; a new request is taken while the last report waits.
// Reset (rst, synchronous) clears the position, the known flag and the screen size to 1920x1080.
module pointer_to_relative_mouse_reports
  import prmr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  prmr_pointer_if.sink         pointer,
  prmr_report_if.source        report
);

  dp_cmd_t    cmd;
  dp_status_t st;
  logic       in_ready;

  assign pointer.ready = in_ready;

  prmr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pointer.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  prmr_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .opcode      (pointer.opcode),
    .button_mask (pointer.button_mask),
    .wheel_step  (pointer.wheel_step),
    .abs_x       (pointer.abs_x),
    .abs_y       (pointer.abs_y),
    .rel_dx      (pointer.rel_dx),
    .rel_dy      (pointer.rel_dy),
    .cmd         (cmd),
    .st          (st),
    .report      (report)
  );

endmodule
